// ===== sv/ojm_pkg.sv =====
// Shared types and codes for the overlap jitter match block.
// No dependencies; imported by every other module of the block.
package ojm_pkg;

  localparam logic [1:0] FUNC_WIN_WRITE = 2'd0;
  localparam logic [1:0] FUNC_REF_WRITE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH    = 2'd2;

  localparam logic [1:0] STATUS_DISABLED = 2'd0;
  localparam logic [1:0] STATUS_NOMATCH  = 2'd1;
  localparam logic [1:0] STATUS_MATCH    = 2'd2;

  localparam logic [1:0] REG_CORR_ENABLE = 2'd0;
  localparam logic [1:0] REG_HALF_WINDOW = 2'd1;
  localparam logic [1:0] REG_MATCH_LEN   = 2'd2;

  localparam int CFG_DATA_W = 11;

  // controller -> datapath commands
  typedef struct packed {
    logic       win_we;
    logic       ref_we;
    logic       clear_pos;
    logic       inc_k;
    logic       next_p;
    logic       finish;
    logic [1:0] status;
  } ojm_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic enable;
    logic fits;
    logic mismatch;
    logic last_k;
  } ojm_sts_t;

endpackage

// ===== sv/ojm_ctrl.sv =====
// Search sequencer for the overlap jitter match block.
// Depends on ojm_pkg; drives ojm_datapath through command/status structs.
module ojm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        in_func,
  input  ojm_pkg::ojm_sts_t sts,
  output ojm_pkg::ojm_cmd_t cmd,
  output logic              busy
);
  import ojm_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_CHECK   = 2'd1;
  localparam logic [1:0] ST_FETCH   = 2'd2;
  localparam logic [1:0] ST_COMPARE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.status    = STATUS_NOMATCH;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_func)
            FUNC_WIN_WRITE: cmd.win_we = 1'b1;
            FUNC_REF_WRITE: cmd.ref_we = 1'b1;
            FUNC_SEARCH: begin
              cmd.clear_pos = 1'b1;
              if (!sts.enable) begin
                cmd.finish = 1'b1;
                cmd.status = STATUS_DISABLED;
              end else begin
                state_nxt = ST_CHECK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        // candidate must leave room for the whole reference
        if (!sts.fits) begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_NOMATCH;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_COMPARE;
      ST_COMPARE: begin
        if (sts.mismatch) begin
          cmd.next_p = 1'b1;
          state_nxt  = ST_CHECK;
        end else if (sts.last_k) begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_MATCH;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.inc_k = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/ojm_datapath.sv =====
// Window/reference stores, config registers, position counters and compare.
// Depends on ojm_pkg; commanded by ojm_ctrl.
module ojm_datapath #(
  parameter int WINDOW_DEPTH = 2048,
  parameter int MATCH_DEPTH  = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [10:0]                    in_position,
  input  logic [7:0]                     in_byte_value,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [ojm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ojm_pkg::ojm_cmd_t              cmd,
  output ojm_pkg::ojm_sts_t              sts,
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic signed [10:0]             out_shift
);
  import ojm_pkg::*;

  localparam int WA    = $clog2(WINDOW_DEPTH);
  localparam int MA    = (MATCH_DEPTH > 1) ? $clog2(MATCH_DEPTH) : 1;
  localparam int SW    = (WA > 13) ? WA : 13;
  localparam int S_TOP = (WINDOW_DEPTH / 2 > 1024) ? 1024 : WINDOW_DEPTH / 2;

  logic [7:0] win_mem [WINDOW_DEPTH];
  logic [7:0] ref_mem [MATCH_DEPTH];
  logic [7:0] win_rd_r, ref_rd_r;

  logic        enable_r;
  logic [10:0] half_r;
  logic [8:0]  len_r;

  logic [SW-1:0] p_r, k_r;
  logic          valid_r;
  logic [1:0]    status_r;
  logic [10:0]   shift_r;

  logic [10:0]   s_eff;
  logic [SW-1:0] len_eff, span, addr_sum;
  logic [WA-1:0] win_waddr, win_raddr;
  logic [MA-1:0] ref_waddr, ref_raddr;
  logic          win_in_range, ref_in_range;
  logic [10:0]   shift_nxt;

  always_comb begin
    if (half_r == 11'd0)              s_eff = 11'd1;
    else if (half_r > 11'(S_TOP))     s_eff = 11'(S_TOP);
    else                              s_eff = half_r;
    if (len_r == 9'd0)                len_eff = SW'(1);
    else if (32'(len_r) > MATCH_DEPTH) len_eff = SW'(MATCH_DEPTH);
    else                              len_eff = SW'(len_r);
  end

  assign span      = SW'({s_eff, 1'b0});
  assign addr_sum  = p_r + k_r;
  assign win_raddr = addr_sum[WA-1:0];
  assign ref_raddr = k_r[MA-1:0];
  assign win_waddr = WA'(in_position);
  assign ref_waddr = MA'(in_position);

  assign win_in_range = (32'(in_position) < WINDOW_DEPTH);
  assign ref_in_range = (32'(in_position) < MATCH_DEPTH);

  assign sts.enable   = enable_r;
  assign sts.fits     = ((p_r + SW'(2)) <= span) && ((p_r + len_eff) <= span);
  assign sts.mismatch = (win_rd_r != ref_rd_r);
  assign sts.last_k   = ((k_r + SW'(1)) == len_eff);

  assign shift_nxt = 11'(p_r) - s_eff;

  always_ff @(posedge clk) begin
    if (cmd.win_we && win_in_range) begin
      win_mem[win_waddr] <= in_byte_value;
    end
    win_rd_r <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ref_we && ref_in_range) begin
      ref_mem[ref_waddr] <= in_byte_value;
    end
    ref_rd_r <= ref_mem[ref_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      half_r   <= 11'd512;
      len_r    <= 9'd64;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
      if (cfg_we) begin
        case (cfg_index)
          REG_CORR_ENABLE: enable_r <= cfg_data[0];
          REG_HALF_WINDOW: half_r   <= cfg_data[10:0];
          REG_MATCH_LEN:   len_r    <= cfg_data[8:0];
          default: ;
        endcase
      end
    end
  end

  // position counters and result payload
  always_ff @(posedge clk) begin
    if (cmd.clear_pos) begin
      p_r <= '0;
      k_r <= '0;
    end else if (cmd.next_p) begin
      p_r <= p_r + SW'(2);
      k_r <= '0;
    end else if (cmd.inc_k) begin
      k_r <= k_r + SW'(1);
    end
    if (cmd.finish) begin
      status_r <= cmd.status;
      shift_r  <= (cmd.status == STATUS_MATCH) ? shift_nxt : 11'd0;
    end
  end

  assign out_strobe = valid_r;
  assign out_status = status_r;
  assign out_shift  = $signed(shift_r);

endmodule

// ===== sv/overlap_jitter_match_core.sv =====
// Top level of the overlap jitter match block: controller plus datapath.
// Depends on ojm_pkg, ojm_ctrl and ojm_datapath.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------
//  input    | in_func, in_position, in_byte_value     | start & !busy
//  result   | out_status, out_shift                   | out_strobe, one cycle
//  config   | cfg_index, cfg_data                     | cfg_we, no wait
//
// Writes and disabled searches finish in their accept cycle and never raise busy.
// An enabled search then holds busy through a check state per candidate plus fetch
// and compare states per compared byte, plus a final check when nothing matches.
// A search strobes its result in the first cycle with busy low after it (the cycle
// right after accept when disabled); the receiver cannot stall.
// Synchronous active-low reset clears config to defaults and the sequencer.
module overlap_jitter_match_core #(
  parameter int WINDOW_DEPTH = 2048,
  parameter int MATCH_DEPTH  = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_func,
  input  logic [10:0]                    in_position,
  input  logic [7:0]                     in_byte_value,
  output logic                           out_strobe,
  output logic [1:0]                     out_status,
  output logic signed [10:0]             out_shift,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [ojm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ojm_pkg::*;

  ojm_cmd_t cmd;
  ojm_sts_t sts;

  ojm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  ojm_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MATCH_DEPTH  (MATCH_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_position   (in_position),
    .in_byte_value (in_byte_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_shift     (out_shift)
  );

endmodule
